// ----- rtl/core/sitda_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg - shared definitions for the signed integer to decimal ASCII core
// Holds the character constants, the conversion step size and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sitda_pkg;

	// default width of the signed input value
	localparam int VALUE_BITS_DEF = 32;

	// magnitude bits shifted into the BCD register per conversion cycle
	localparam int BITS_PER_STEP = 4;

	// bits of one BCD digit
	localparam int DIGIT_BITS = 4;

	// character codes
	localparam logic [6:0] CH_MINUS = 7'd45;
	localparam logic [6:0] CH_ZERO  = 7'd48;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture a new value, clear the BCD register
		logic step;      // one shift-and-correct conversion cycle
		logic find;      // locate the leading non-zero digit
		logic adv;       // current digit word taken, move to the next digit
		logic sign_sel;  // present the minus sign instead of a digit
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic conv_done; // this is the final conversion cycle
		logic ptr_zero;  // digit pointer at the least significant digit
		logic neg;       // captured value is negative
	} dp_sts_t;

endpackage : sitda_pkg
`default_nettype wire

// ----- rtl/core/sitda_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_dp - conversion datapath
// Forms the unsigned magnitude, converts it to BCD by shift-and-add-3 a few
// bits per cycle, finds the leading digit and drives the outgoing character.
// ----------------------------------------------------------------------------
module sitda_dp
	import sitda_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts,
	output logic [6:0]                 char_code,
	output logic                       last
);

	localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int MAG_W = STEPS * BITS_PER_STEP;
	// decimal digits of 2^VALUE_BITS - 1 (log10(2) ~ 0.30103)
	localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W = NDIG * DIGIT_BITS;
	localparam int CNT_W = $clog2(STEPS);
	localparam int PTR_W = $clog2(NDIG);

	logic                  neg_q;
	logic [MAG_W-1:0]      mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PTR_W-1:0]      ptr_q;

	logic [VALUE_BITS-1:0] mag_in;
	logic [MAG_W-1:0]      mag_nxt;
	logic [BCD_W-1:0]      bcd_nxt;
	logic [PTR_W-1:0]      lead_ptr;
	logic [DIGIT_BITS-1:0] cur_digit;

	// magnitude of the incoming value, unsigned so the most negative fits
	assign mag_in = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

	// shift-and-add-3 over BITS_PER_STEP bits
	always_comb begin
		bcd_nxt = bcd_q;
		mag_nxt = mag_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_nxt[d*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
					bcd_nxt[d*DIGIT_BITS +: DIGIT_BITS] =
						bcd_nxt[d*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
				end
			end
			bcd_nxt = {bcd_nxt[BCD_W-2:0], mag_nxt[MAG_W-1]};
			mag_nxt = {mag_nxt[MAG_W-2:0], 1'b0};
		end
	end

	// leading non-zero digit, least significant digit when all are zero
	always_comb begin
		lead_ptr = '0;
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
				lead_ptr = PTR_W'(d);
			end
		end
	end

	// step counter (control state)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_BITS-1];
			mag_q <= MAG_W'(mag_in);
			bcd_q <= '0;
		end else if (cmd.step) begin
			mag_q <= mag_nxt;
			bcd_q <= bcd_nxt;
		end
		if (cmd.find) begin
			ptr_q <= lead_ptr;
		end else if (cmd.adv && (ptr_q != '0)) begin
			ptr_q <= ptr_q - PTR_W'(1);
		end
	end

	assign cur_digit = bcd_q[ptr_q*DIGIT_BITS +: DIGIT_BITS];

	// outgoing character
	assign char_code = cmd.sign_sel ? CH_MINUS : (CH_ZERO + {3'b000, cur_digit});
	assign last      = !cmd.sign_sel && (ptr_q == '0);

	assign sts.conv_done = (cnt_q == CNT_W'(STEPS - 1));
	assign sts.ptr_zero  = (ptr_q == '0);
	assign sts.neg       = neg_q;

endmodule : sitda_dp
`default_nettype wire

// ----- rtl/core/sitda_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_ctrl - sequencing controller
// Walks each value through capture, conversion, leading digit search and
// character output, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module sitda_ctrl
	import sitda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_FIND = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_CONV;
			end
			ST_CONV: begin
				if (sts.conv_done) state_nxt = ST_FIND;
			end
			ST_FIND: begin
				state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (m_tready) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (m_tready && sts.ptr_zero) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// handshakes and datapath commands
	assign s_tready     = (state_q == ST_IDLE);
	assign m_tvalid     = (state_q == ST_SIGN) || (state_q == ST_EMIT);
	assign cmd.load     = s_tvalid && s_tready;
	assign cmd.step     = (state_q == ST_CONV);
	assign cmd.find     = (state_q == ST_FIND);
	assign cmd.adv      = (state_q == ST_EMIT) && m_tready;
	assign cmd.sign_sel = (state_q == ST_SIGN);

	// input is never taken while a character word is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while output valid");

	// a captured value always starts conversion
	a_load_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_CONV))
		else $error("conversion did not follow capture");

	// the final digit word returns the controller to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.adv && sts.ptr_zero) |=> (state_q == ST_IDLE))
		else $error("not idle after final character");

	// a sign word is always followed by digits
	a_sign_emit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SIGN) && m_tready) |=> (state_q == ST_EMIT))
		else $error("sign not followed by digits");

endmodule : sitda_ctrl
`default_nettype wire

// ----- rtl/core/signed_int_to_decimal_ascii_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core - signed integer to decimal ASCII text
// Converts each two's complement word into its decimal characters, most
// significant first, with a leading '-' for negative values.
//
// Channel  Dir  Word contents (low bits first)         Per value
// s_*      in   tdata: value [VALUE_BITS-1:0]           one word
// m_*      out  tdata: char_code [6:0], zero bit [7]    1..NDIG+1 words
//                tlast: final character of the value
//
// Each value passes through capture, conversion, the leading digit search
// and then one output word per character.
// The shift-and-add-3 loop, four bits a cycle, sets the conversion time.
// Values are handled one at a time; s_tready is high only when idle.
// A stalled m_tready holds the current character word unchanged.
// Reset clears the controller and step counter; no clearing pass follows.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// slave side: value
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,   // value
	// master side: characters
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [7:0]                              m_tdata,   // char_code, zero pad
	output logic                                    m_tlast    // last
);

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [6:0] char_code;

	// sequencing
	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// conversion datapath
	sitda_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata[VALUE_BITS-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.char_code (char_code),
		.last      (m_tlast)
	);

	assign m_tdata = {1'b0, char_code};

endmodule : signed_int_to_decimal_ascii_core
`default_nettype wire

// ----- test/signed_int_to_decimal_ascii_core_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_test - self-checking bench for the core
// Feeds signed 32-bit words: first a table of edge values, then random words
// aimed at digit-count boundaries, small numbers and the full range. Each
// character word is checked against typed text or a decimal formatter in
// the bench, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_test;
	import sitda_pkg::*;

	localparam int VALUE_BITS   = 32;
	localparam int N_DIRECTED   = 24;
	localparam int N_RANDOM     = 456;
	localparam int STALL_PCT    = 30;
	localparam int QUIET_LIMIT  = 2000;  // cycles with no accepted word
	localparam int DRAIN_CYCLES = 40;    // extra wait beyond the slowest value

	// one character word as it leaves the core
	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} char_word_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [VALUE_BITS-1:0] s_tdata  = '0;  // value
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // char_code [6:0], zero pad [7]
	logic                  m_tlast;        // last

	char_word_t  pending_chars[$];
	int          error_count = 0;
	int          quiet_cycles = 0;
	logic        steady = 1'b0;   // no gaps or stalls while set

	int unsigned pow10 [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
		10000000, 100000000, 1000000000};

	// edge values; an empty text means the formatter supplies the expectation
	logic [31:0] edge_value [N_DIRECTED] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
		32'h0000_000A, 32'hFFFF_FFF6, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h8000_0001, 32'd1000000000, 32'd999999999, -32'sd1000000000,
		32'd5, 32'd42, -32'sd7, 32'd123456789,
		-32'sd98765, 32'd4096, 32'hAAAA_AAAA, 32'h5555_5555,
		32'd65535, -32'sd65536, 32'd100, -32'sd99};
	string edge_text [N_DIRECTED] = '{
		"0", "1", "-1", "9",
		"10", "-10", "2147483647", "-2147483648",
		"-2147483647", "1000000000", "999999999", "-1000000000",
		"", "", "", "",
		"", "", "", "",
		"", "", "", ""};

	signed_int_to_decimal_ascii_core #(
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// decimal text of a two's complement value: sign, then digits MSD first
	task automatic queue_decimal_text(input logic [31:0] value);
		logic [31:0] mag;
		int          digit [10];
		int          n;
		char_word_t  w;
		mag = value[31] ? (~value + 32'd1) : value;
		n = 0;
		do begin
			digit[n] = int'(mag % 32'd10);
			mag = mag / 32'd10;
			n++;
		end while (mag != 0);
		if (value[31]) begin
			w.code = CH_MINUS;
			w.last = 1'b0;
			pending_chars.push_back(w);
		end
		for (int i = n - 1; i >= 0; i--) begin
			w.code = CH_ZERO + 7'(digit[i]);
			w.last = (i == 0);
			pending_chars.push_back(w);
		end
	endtask

	task automatic queue_typed_text(input string text);
		char_word_t w;
		for (int i = 0; i < text.len(); i++) begin
			w.code = 7'(text[i]);
			w.last = (i == text.len() - 1);
			pending_chars.push_back(w);
		end
	endtask

	// random value: full range, shortened, small, or near a power of ten
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		int          mode;
		mode = $urandom_range(0, 3);
		case (mode)
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(0, 31);
			2: v = $urandom_range(0, 999);
			default: v = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
		endcase
		if (mode != 0 && $urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// offer one value word, with random gaps, and book its characters
	task automatic send_value(input logic [31:0] value, input string text);
		while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (text.len() != 0)
			queue_typed_text(text);
		else
			queue_decimal_text(value);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// output stalls
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
	end

	// character check against the oldest booked word
	always @(posedge clk) begin : char_check
		char_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected char %0d last %0b",
					m_tdata[6:0], m_tlast));
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata[6:0] != want.code)
					flag_mismatch($sformatf("char_code %0d, want %0d",
						m_tdata[6:0], want.code));
				if (m_tlast != want.last)
					flag_mismatch($sformatf("last %0b, want %0b on char %0d",
						m_tlast, want.last, want.code));
			end
		end
	end

	// watchdog on cycles where neither side moves a word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_value(edge_value[i], edge_text[i]);
		hold_until_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 150)
				steady <= 1'b1;
			else if (i == 270)
				steady <= 1'b0;
			if (i == 300)
				hold_until_drained();
			send_value(pick_value(), "");
		end
		s_tvalid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule : signed_int_to_decimal_ascii_core_test
`default_nettype wire

// ----- sim.f -----
rtl/core/sitda_pkg.sv
rtl/core/sitda_dp.sv
rtl/core/sitda_ctrl.sv
rtl/core/signed_int_to_decimal_ascii_core.sv
test/signed_int_to_decimal_ascii_core_test.sv
